// ===== design/plic_volume_from_plane_constant_assert.svh =====
// assertion macros for the plic volume block
`ifndef PLIC_VOLUME_FROM_PLANE_CONSTANT_ASSERT_SVH
`define PLIC_VOLUME_FROM_PLANE_CONSTANT_ASSERT_SVH
`ifndef SYNTH
// expression holds at every edge outside reset
`define PV_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
// antecedent implies consequent at the next edge
`define PV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PV_ASSERT(label, clk, rst, expr)
`define PV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/plicv_pkg.sv =====
// shared types for the plic volume block
`timescale 1ns / 1ps
package plicv_pkg;
   // analytic case chosen for a cell
   typedef enum logic [2:0] {
      CASE_CORNER,
      CASE_PRISM,
      CASE_FOLD,
      CASE_FULL,
      CASE_SLAB
   } vf_case_type;
endpackage

// ===== design/plic_volume_from_plane_constant.sv =====
// cut volume fraction of a unit cube under a plane, fully pipelined
//
//   channel | dir | ports
//   req     | in  | req_valid, req_stall, req_plane_constant, req_normal_x/y/z
//   rsp     | out | rsp_valid, rsp_stall, rsp_volume_fraction
//
// one beat in and one beat out per cycle while the output is not stalled; the pipe holds
// five arithmetic stages, one setup stage, FRAC_BITS + 2 divider stages and an output stage
// the restoring divider, one quotient bit per stage, sets the depth
// reset is synchronous and clears every valid bit
// a stalled output freezes the whole pipe, nothing is dropped or repeated
`timescale 1ns / 1ps
`include "plic_volume_from_plane_constant_assert.svh"
module plic_volume_from_plane_constant #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [FRAC_BITS:0]   req_plane_constant,
   input  logic [FRAC_BITS:0]   req_normal_x,
   input  logic [FRAC_BITS:0]   req_normal_y,
   input  logic [FRAC_BITS:0]   req_normal_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [FRAC_BITS:0]   rsp_volume_fraction
);
   import plicv_pkg::*;

   localparam int F1 = FRAC_BITS + 1;
   localparam int PW = 2 * F1;
   localparam int NW = 3 * F1 + 5;
   localparam int QW = FRAC_BITS + 2;
   localparam int DW = NW + FRAC_BITS + 2;
   localparam logic [F1-1:0] ONE = F1'(1) << FRAC_BITS;

   logic en;

   // whole pipe advances unless the output beat is held
   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: clamp, fold alpha, sort normals
   logic          v1_ff;
   logic [F1-1:0] a1_ff, m1_1_ff, m3_1_ff;
   logic          mir1_ff;
   logic [F1-1:0] al_s, nx_s, ny_s, nz_s, a1_in, m1_1_in, m3_1_in;

   always_comb begin
      al_s = (req_plane_constant > ONE) ? ONE : req_plane_constant;
      nx_s = (req_normal_x > ONE) ? ONE : req_normal_x;
      ny_s = (req_normal_y > ONE) ? ONE : req_normal_y;
      nz_s = (req_normal_z > ONE) ? ONE : req_normal_z;
      a1_in = (al_s <= ONE - al_s) ? al_s : ONE - al_s;
      m1_1_in = nx_s;
      if (ny_s < m1_1_in) m1_1_in = ny_s;
      if (nz_s < m1_1_in) m1_1_in = nz_s;
      m3_1_in = nx_s;
      if (ny_s > m3_1_in) m3_1_in = ny_s;
      if (nz_s > m3_1_in) m3_1_in = nz_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
      if (en) begin
         a1_ff   <= a1_in;
         m1_1_ff <= m1_1_in;
         m3_1_ff <= m3_1_in;
         mir1_ff <= (al_s > (ONE >> 1));
      end
   end

   // stage 2: middle normal, case select, linear terms
   logic          v2_ff, mir2_ff, az2_ff;
   logic [F1-1:0] a2_ff, m1_2_ff, m2_2_ff, m3_2_ff, am2_ff;
   logic [F1:0]   m12_2_ff;
   logic [F1+2:0] t3_2_ff;
   logic [F1+1:0] t4_2_ff, a3x_2_ff;
   vf_case_type   cs2_ff;
   logic [F1:0]   s_2, lim_2, m12_2_in;
   logic [F1-1:0] m2_2_in;
   vf_case_type   cs2_in;

   always_comb begin
      s_2 = {1'b0, m1_1_ff} + {1'b0, m3_1_ff};
      m2_2_in = (s_2 > {1'b0, ONE}) ? F1'(s_2 - {1'b0, ONE}) : F1'({1'b0, ONE} - s_2);
      m12_2_in = {1'b0, m1_1_ff} + {1'b0, m2_2_in};
      lim_2 = (m12_2_in < {1'b0, m3_1_ff}) ? m12_2_in : {1'b0, m3_1_ff};
      if (a1_ff < m1_1_ff) begin
         cs2_in = CASE_CORNER;
      end else if (a1_ff < m2_2_in) begin
         cs2_in = CASE_PRISM;
      end else if ({1'b0, a1_ff} < lim_2) begin
         cs2_in = CASE_FOLD;
      end else if ({1'b0, m3_1_ff} < m12_2_in) begin
         cs2_in = CASE_FULL;
      end else begin
         cs2_in = CASE_SLAB;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         a2_ff    <= a1_ff;
         m1_2_ff  <= m1_1_ff;
         m2_2_ff  <= m2_2_in;
         m3_2_ff  <= m3_1_ff;
         am2_ff   <= a1_ff - m1_1_ff;
         m12_2_ff <= m12_2_in;
         t3_2_ff  <= 3'd3 * (F1+3)'(m12_2_in) - (F1+3)'(a1_ff);
         t4_2_ff  <= (F1+2)'(3) * (F1+2)'(ONE) - ((F1+2)'(a1_ff) << 1);
         a3x_2_ff <= (F1+2)'(3) * (F1+2)'(a1_ff);
         cs2_ff   <= cs2_in;
         mir2_ff  <= mir1_ff;
         az2_ff   <= (a1_ff == '0);
      end
   end

   // stage 3: first products
   logic          v3_ff, mir3_ff, az3_ff;
   logic [F1-1:0] a3_ff, m1_3_ff, m2_3_ff, m3_3_ff;
   logic [F1:0]   m12_3_ff;
   logic [F1+2:0] t3_3_ff;
   logic [F1+1:0] t4_3_ff, a3x_3_ff;
   vf_case_type   cs3_ff;
   logic [PW-1:0] aa_ff, m1sq_ff, m2sq_ff, m3sq_ff, m1m2_ff, m2m3_ff, aam_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         aa_ff    <= PW'(a2_ff) * PW'(a2_ff);
         m1sq_ff  <= PW'(m1_2_ff) * PW'(m1_2_ff);
         m2sq_ff  <= PW'(m2_2_ff) * PW'(m2_2_ff);
         m3sq_ff  <= PW'(m3_2_ff) * PW'(m3_2_ff);
         m1m2_ff  <= PW'(m1_2_ff) * PW'(m2_2_ff);
         m2m3_ff  <= PW'(m2_2_ff) * PW'(m3_2_ff);
         aam_ff   <= PW'(a2_ff) * PW'(am2_ff);
         a3_ff    <= a2_ff;
         m1_3_ff  <= m1_2_ff;
         m2_3_ff  <= m2_2_ff;
         m3_3_ff  <= m3_2_ff;
         m12_3_ff <= m12_2_ff;
         t3_3_ff  <= t3_2_ff;
         t4_3_ff  <= t4_2_ff;
         a3x_3_ff <= a3x_2_ff;
         cs3_ff   <= cs2_ff;
         mir3_ff  <= mir2_ff;
         az3_ff   <= az2_ff;
      end
   end

   // stage 4: second products
   logic          v4_ff, mir4_ff, az4_ff;
   vf_case_type   cs4_ff;
   logic [NW-1:0] acub_ff, m1c_ff, m2c_ff, m3c_ff, p3_ff, p4_ff, n3_ff, n4_ff;
   logic [NW-1:0] d6_ff, c2n_ff, d2_ff, a2x_ff, m12_4_ff, m3x2_ff;
   logic [NW-1:0] sq12_4, sq123_4;

   always_comb begin
      sq12_4  = NW'(m1sq_ff) + NW'(m2sq_ff);
      sq123_4 = sq12_4 + NW'(m3sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         acub_ff  <= NW'(aa_ff) * NW'(a3_ff);
         m1c_ff   <= NW'(m1sq_ff) * NW'(m1_3_ff);
         m2c_ff   <= NW'(m2sq_ff) * NW'(m2_3_ff);
         m3c_ff   <= NW'(m3sq_ff) * NW'(m3_3_ff);
         p3_ff    <= NW'(aa_ff) * NW'(t3_3_ff);
         p4_ff    <= NW'(aa_ff) * NW'(t4_3_ff);
         n3_ff    <= NW'(a3x_3_ff) * sq12_4;
         n4_ff    <= NW'(a3x_3_ff) * sq123_4;
         d6_ff    <= NW'(m1m2_ff) * NW'(m3_3_ff);
         c2n_ff   <= NW'(aam_ff) * NW'(3) + NW'(m1sq_ff);
         d2_ff    <= (NW'(m2m3_ff) << 2) + (NW'(m2m3_ff) << 1);
         a2x_ff   <= NW'(a3_ff) << 1;
         m12_4_ff <= NW'(m12_3_ff);
         m3x2_ff  <= NW'(m3_3_ff) << 1;
         cs4_ff   <= cs3_ff;
         mir4_ff  <= mir3_ff;
         az4_ff   <= az3_ff;
      end
   end

   // stage 5: numerator and denominator per case
   logic          v5_ff, mir5_ff, az5_ff;
   logic [NW-1:0] num5_ff, den5_ff;
   logic [NW-1:0] num5_in, den5_in, pos5, neg5, d6x6;

   always_comb begin
      d6x6 = (d6_ff << 2) + (d6_ff << 1);
      pos5 = '0;
      neg5 = '0;
      num5_in = '0;
      den5_in = d6x6;
      case (cs4_ff)
         CASE_CORNER: begin
            num5_in = acub_ff;
         end
         CASE_PRISM: begin
            num5_in = c2n_ff;
            den5_in = d2_ff;
         end
         CASE_FOLD: begin
            pos5 = p3_ff + m1c_ff + m2c_ff;
            neg5 = n3_ff;
            num5_in = (pos5 >= neg5) ? pos5 - neg5 : '0;
         end
         CASE_FULL: begin
            pos5 = p4_ff + m1c_ff + m2c_ff + m3c_ff;
            neg5 = n4_ff;
            num5_in = (pos5 >= neg5) ? pos5 - neg5 : '0;
         end
         CASE_SLAB: begin
            num5_in = (a2x_ff >= m12_4_ff) ? a2x_ff - m12_4_ff : '0;
            den5_in = m3x2_ff;
         end
         default: begin
            num5_in = '0;
            den5_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         num5_ff <= num5_in;
         den5_ff <= den5_in;
         mir5_ff <= mir4_ff;
         az5_ff  <= az4_ff;
      end
   end

   // divider stage registers, index 0 is the setup stage
   logic          dv_ff   [0:QW];
   logic          dsat_ff [0:QW];
   logic          dzero_ff[0:QW];
   logic          dmir_ff [0:QW];
   logic [DW-1:0] drem_ff [0:QW];
   logic [NW-1:0] dden_ff [0:QW];
   logic [QW-1:0] dq_ff   [0:QW];

   // setup: zero and overflow detect, dividend scaled up
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v5_ff;
      end
      if (en) begin
         dsat_ff[0]  <= ((NW+2)'(num5_ff) >= ((NW+2)'(den5_ff) << 2));
         dzero_ff[0] <= az5_ff || (den5_ff == '0);
         dmir_ff[0]  <= mir5_ff;
         drem_ff[0]  <= DW'(num5_ff) << FRAC_BITS;
         dden_ff[0]  <= den5_ff;
         dq_ff[0]    <= '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DW-1:0] sh;
      logic          ge;

      assign sh = DW'(dden_ff[k]) << (QW - 1 - k);
      assign ge = (drem_ff[k] >= sh);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         if (en) begin
            drem_ff[k+1]  <= ge ? drem_ff[k] - sh : drem_ff[k];
            dq_ff[k+1]    <= dq_ff[k] | (ge ? (QW'(1) << (QW - 1 - k)) : QW'(0));
            dden_ff[k+1]  <= dden_ff[k];
            dsat_ff[k+1]  <= dsat_ff[k];
            dzero_ff[k+1] <= dzero_ff[k];
            dmir_ff[k+1]  <= dmir_ff[k];
         end
      end
   end

   // output: saturate, mirror, hold while stalled
   logic          rsp_valid_ff;
   logic [F1-1:0] rsp_vf_ff;
   logic [F1-1:0] vq, vf_in;

   always_comb begin
      if (dzero_ff[QW]) begin
         vq = '0;
      end else if (dsat_ff[QW] || (dq_ff[QW] > QW'(ONE))) begin
         vq = ONE;
      end else begin
         vq = dq_ff[QW][F1-1:0];
      end
      vf_in = dmir_ff[QW] ? ONE - vq : vq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[QW];
      end
      if (en) begin
         rsp_vf_ff <= vf_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_volume_fraction = rsp_vf_ff;

   `PV_ASSERT(a_out_range, clock, reset, !rsp_valid || (rsp_volume_fraction <= ONE))
   `PV_ASSERT(a_stall_cause, clock, reset, !req_stall || rsp_valid)
   `PV_ASSERT_NEXT(a_last_reaches_out, clock, reset, en && dv_ff[QW], rsp_valid)
endmodule
